[rtl/bur_pkg.sv]
package bur_pkg;

  typedef enum logic [1:0] {
    MODE_SERVICE = 2'd0,
    MODE_PUT     = 2'd1,
    MODE_GET     = 2'd2
  } mode_t;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned READ_W      = 16;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [READ_W-1:0] EMPTY_READ = 16'hFFFF;

endpackage

[rtl/bur_ram.sv]
module bur_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/buffered_uart_ring_buffers_unit.sv]
// Receive and transmit byte rings between a serial port and a processor.
// Input channel (in_*): one transfer per operation. in_tdata carries mode
// (0 service, 1 put, 2 get), rx_flag, tx_flag and data_byte.
// Output channel (out_*): exactly one result transfer per input transfer,
// in order: tx_send, tx_byte, rx_dropped, put_count, tx_kick, read_value.
// Each ring lives in a RAM with a registered read; pointers and
// fill levels are in flops and update when the input transfer is taken, so
// the RAM write or read for an item is issued in its accept cycle.
// The result passes through the read stage and then the output register.
// Throughput: one item per cycle unless out_tready stalls, set by the single
// RAM access per ring per item and the one-entry stage awaiting read data.
// Reset empties both rings (pointers to zero); RAM contents are not cleared
// and are only read after being written.
// When out_tready is low the result holds, one more item may sit in the
// read stage, and in_tready then drops until the output drains.
module buffered_uart_ring_buffers_unit #(
  parameter int unsigned RING_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] mode, [2] rx_flag, [3] tx_flag, [11:4] data_byte, [15:12] zero
  input  logic [bur_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] tx_send, [8:1] tx_byte, [9] rx_dropped, [14:10] put_count,
  // [15] tx_kick, [31:16] read_value
  output logic [bur_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import bur_pkg::*;

  localparam int unsigned AW    = $clog2(RING_DEPTH);
  localparam int unsigned PTR_W = AW + 1;
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(RING_DEPTH);
  localparam logic [AW-1:0]    LAST_IX = AW'(RING_DEPTH - 1);

  logic [AW-1:0] rx_rix_r, rx_wix_r, tx_rix_r, tx_wix_r;
  logic          rx_rph_r, rx_wph_r, tx_rph_r, tx_wph_r;
  logic [AW-1:0] rx_rix_nxt, rx_wix_nxt, tx_rix_nxt, tx_wix_nxt;
  logic          rx_rph_nxt, rx_wph_nxt, tx_rph_nxt, tx_wph_nxt;

  logic [PTR_W-1:0] rx_fill, tx_fill;

  logic             s1_v_r, s1_send_r, s1_drop_r, s1_kick_r, s1_hit_r, s1_empty_r;
  logic [COUNT_W-1:0] s1_count_r;
  logic             s1_send_nxt, s1_drop_nxt, s1_kick_nxt, s1_hit_nxt, s1_empty_nxt;
  logic [COUNT_W-1:0] s1_count_nxt;

  logic                   out_v_r;
  logic [OUT_TDATA_W-1:0] out_d_r;
  logic [OUT_TDATA_W-1:0] out_d_nxt;

  logic               accept, load;
  mode_t              mode;
  logic               rx_flag, tx_flag;
  logic [BYTE_W-1:0]  data_byte;
  logic               rx_we, rx_re, tx_we, tx_re;
  logic [BYTE_W-1:0]  rx_rdata, tx_rdata;
  logic [BYTE_W-1:0]  tx_byte;
  logic [READ_W-1:0]  read_value;

  function automatic logic [PTR_W-1:0] fill_of(logic [AW-1:0] wix, logic wph,
                                               logic [AW-1:0] rix, logic rph);
    logic [PTR_W-1:0] res;
    if (wph == rph) begin
      res = PTR_W'(wix) - PTR_W'(rix);
    end else begin
      res = DEPTH_P + PTR_W'(wix) - PTR_W'(rix);
    end
    return res;
  endfunction

  assign rx_fill = fill_of(rx_wix_r, rx_wph_r, rx_rix_r, rx_rph_r);
  assign tx_fill = fill_of(tx_wix_r, tx_wph_r, tx_rix_r, tx_rph_r);

  assign load      = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || load;
  assign accept    = in_tvalid && in_tready;

  assign mode      = mode_t'(in_tdata[1:0]);
  assign rx_flag   = in_tdata[2];
  assign tx_flag   = in_tdata[3];
  assign data_byte = in_tdata[11:4];

  always_comb begin
    rx_we        = 1'b0;
    rx_re        = 1'b0;
    tx_we        = 1'b0;
    tx_re        = 1'b0;
    s1_send_nxt  = 1'b0;
    s1_drop_nxt  = 1'b0;
    s1_kick_nxt  = 1'b0;
    s1_hit_nxt   = 1'b0;
    s1_empty_nxt = 1'b0;
    s1_count_nxt = '0;
    case (mode)
      MODE_SERVICE: begin
        rx_we       = rx_flag && (rx_fill < DEPTH_P);
        s1_drop_nxt = rx_flag && !(rx_fill < DEPTH_P);
        tx_re       = tx_flag && (tx_fill != '0);
        s1_send_nxt = tx_re;
      end
      MODE_PUT: begin
        tx_we        = tx_fill < DEPTH_P;
        s1_count_nxt = COUNT_W'(tx_fill);
        s1_kick_nxt  = 1'b1;
      end
      MODE_GET: begin
        rx_re        = rx_fill != '0;
        s1_hit_nxt   = rx_re;
        s1_empty_nxt = !rx_re;
      end
      default: begin
      end
    endcase
    rx_we = rx_we && accept;
    rx_re = rx_re && accept;
    tx_we = tx_we && accept;
    tx_re = tx_re && accept;

    rx_wix_nxt = rx_wix_r;  rx_wph_nxt = rx_wph_r;
    rx_rix_nxt = rx_rix_r;  rx_rph_nxt = rx_rph_r;
    tx_wix_nxt = tx_wix_r;  tx_wph_nxt = tx_wph_r;
    tx_rix_nxt = tx_rix_r;  tx_rph_nxt = tx_rph_r;
    if (rx_we) begin
      rx_wix_nxt = (rx_wix_r == LAST_IX) ? '0 : rx_wix_r + AW'(1);
      rx_wph_nxt = rx_wph_r ^ (rx_wix_r == LAST_IX);
    end
    if (rx_re) begin
      rx_rix_nxt = (rx_rix_r == LAST_IX) ? '0 : rx_rix_r + AW'(1);
      rx_rph_nxt = rx_rph_r ^ (rx_rix_r == LAST_IX);
    end
    if (tx_we) begin
      tx_wix_nxt = (tx_wix_r == LAST_IX) ? '0 : tx_wix_r + AW'(1);
      tx_wph_nxt = tx_wph_r ^ (tx_wix_r == LAST_IX);
    end
    if (tx_re) begin
      tx_rix_nxt = (tx_rix_r == LAST_IX) ? '0 : tx_rix_r + AW'(1);
      tx_rph_nxt = tx_rph_r ^ (tx_rix_r == LAST_IX);
    end
  end

  bur_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wix_r),
    .wdata (data_byte),
    .re    (rx_re),
    .raddr (rx_rix_r),
    .rdata (rx_rdata)
  );

  bur_ram #(.WIDTH(BYTE_W), .DEPTH(RING_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wix_r),
    .wdata (data_byte),
    .re    (tx_re),
    .raddr (tx_rix_r),
    .rdata (tx_rdata)
  );

  always_comb begin
    tx_byte = s1_send_r ? tx_rdata : '0;
    if (s1_hit_r) begin
      read_value = {{(READ_W - BYTE_W){1'b0}}, rx_rdata};
    end else if (s1_empty_r) begin
      read_value = EMPTY_READ;
    end else begin
      read_value = '0;
    end
    out_d_nxt = {read_value, s1_kick_r, s1_count_r, s1_drop_r, tx_byte, s1_send_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_rix_r <= '0;  rx_rph_r <= 1'b0;
      rx_wix_r <= '0;  rx_wph_r <= 1'b0;
      tx_rix_r <= '0;  tx_rph_r <= 1'b0;
      tx_wix_r <= '0;  tx_wph_r <= 1'b0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      rx_rix_r <= rx_rix_nxt;  rx_rph_r <= rx_rph_nxt;
      rx_wix_r <= rx_wix_nxt;  rx_wph_r <= rx_wph_nxt;
      tx_rix_r <= tx_rix_nxt;  tx_rph_r <= tx_rph_nxt;
      tx_wix_r <= tx_wix_nxt;  tx_wph_r <= tx_wph_nxt;
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (load) begin
        s1_v_r <= 1'b0;
      end
      if (load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_send_r  <= s1_send_nxt;
      s1_drop_r  <= s1_drop_nxt;
      s1_kick_r  <= s1_kick_nxt;
      s1_hit_r   <= s1_hit_nxt;
      s1_empty_r <= s1_empty_nxt;
      s1_count_r <= s1_count_nxt;
    end
    if (load) begin
      out_d_r <= out_d_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  a_rx_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rx_fill <= DEPTH_P) else $error("rx ring fill above depth");

  a_tx_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tx_fill <= DEPTH_P) else $error("tx ring fill above depth");

  a_idle_tx_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_d_r[0]) |-> (out_d_r[8:1] == '0))
    else $error("tx_byte set without tx_send");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_v_r) else $error("result lost between stage and output");

endmodule

[bench/buffered_uart_ring_buffers_unit_tb.sv]
`timescale 1ns / 1ps

module buffered_uart_ring_buffers_unit_tb;
  import bur_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned PTR_W = $clog2(2 * DEPTH);
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [1:0]        mode;
    logic              rx_flag;
    logic              tx_flag;
    logic [BYTE_W-1:0] data_byte;
  } uart_op_t;

  // packed from the top bit down, so tx_send lands in bit 0 of out_tdata
  typedef struct packed {
    logic [READ_W-1:0]  read_value;
    logic               tx_kick;
    logic [COUNT_W-1:0] put_count;
    logic               rx_dropped;
    logic [BYTE_W-1:0]  tx_byte;
    logic               tx_send;
  } uart_res_t;

  typedef enum int {
    MIX_RX_FILL,
    MIX_TX_FILL,
    MIX_RX_DRAIN,
    MIX_TX_DRAIN,
    MIX_ANY
  } op_mix_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  buffered_uart_ring_buffers_unit #(.RING_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // shadow copy of the rings
  logic [BYTE_W-1:0] rx_ring [DEPTH];
  logic [BYTE_W-1:0] tx_ring [DEPTH];
  logic [PTR_W-1:0]  rx_rd, rx_wr, tx_rd, tx_wr;

  uart_res_t pending_results[$];
  int unsigned errors;
  int unsigned n_sent, n_checked, n_drops, n_full_puts, n_empty_gets, n_tx_sent;
  bit          calm;
  int unsigned hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic uart_res_t ring_step(uart_op_t op);
    uart_res_t        r;
    logic [PTR_W-1:0] fill;
    r = '0;
    case (op.mode)
      MODE_SERVICE: begin
        if (op.rx_flag) begin
          fill = rx_wr - rx_rd;
          if (fill < DEPTH) begin
            rx_ring[rx_wr[PTR_W-2:0]] = op.data_byte;
            rx_wr++;
          end else begin
            r.rx_dropped = 1'b1;
            n_drops++;
          end
        end
        if (op.tx_flag) begin
          fill = tx_wr - tx_rd;
          if (fill > 0) begin
            r.tx_byte = tx_ring[tx_rd[PTR_W-2:0]];
            r.tx_send = 1'b1;
            tx_rd++;
            n_tx_sent++;
          end
        end
      end
      MODE_PUT: begin
        fill = tx_wr - tx_rd;
        if (fill < DEPTH) begin
          tx_ring[tx_wr[PTR_W-2:0]] = op.data_byte;
          tx_wr++;
        end else begin
          n_full_puts++;
        end
        r.put_count = COUNT_W'(fill);
        r.tx_kick = 1'b1;
      end
      MODE_GET: begin
        fill = rx_wr - rx_rd;
        if (fill > 0) begin
          r.read_value = READ_W'(rx_ring[rx_rd[PTR_W-2:0]]);
          rx_rd++;
        end else begin
          r.read_value = EMPTY_READ;
          n_empty_gets++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_op(uart_op_t op);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, op.data_byte, op.tx_flag, op.rx_flag, op.mode};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(ring_step(op));
    n_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_fields(logic [1:0] mode, logic rx_f, logic tx_f, logic [7:0] data);
    uart_op_t op;
    op.mode = mode;
    op.rx_flag = rx_f;
    op.tx_flag = tx_f;
    op.data_byte = data;
    send_op(op);
  endtask

  function automatic uart_op_t random_op(op_mix_t mix);
    uart_op_t    op;
    int unsigned r;
    r = $urandom_range(0, 99);
    op.data_byte = BYTE_W'($urandom_range(0, 255));
    op.rx_flag = 1'($urandom_range(0, 1));
    op.tx_flag = 1'($urandom_range(0, 1));
    case (mix)
      MIX_RX_FILL: begin
        op.mode = (r < 80) ? MODE_SERVICE : (r < 90) ? MODE_GET : MODE_PUT;
        op.rx_flag = ($urandom_range(0, 9) != 0);
      end
      MIX_RX_DRAIN: op.mode = (r < 70) ? MODE_GET : MODE_SERVICE;
      MIX_TX_FILL: begin
        op.mode = (r < 70) ? MODE_PUT : MODE_SERVICE;
        if (op.mode == MODE_SERVICE) op.tx_flag = ($urandom_range(0, 9) == 0);
      end
      MIX_TX_DRAIN: begin
        op.mode = (r < 70) ? MODE_SERVICE : MODE_PUT;
        if (op.mode == MODE_SERVICE) op.tx_flag = ($urandom_range(0, 9) != 0);
      end
      default: begin
        if (r < 3) op.mode = MODE_UNUSED;
        else op.mode = (r < 40) ? MODE_SERVICE : (r < 70) ? MODE_PUT : MODE_GET;
      end
    endcase
    return op;
  endfunction

  task automatic test_corner_cases();
    send_fields(MODE_GET, 1'b0, 1'b0, 8'h00);
    send_fields(MODE_SERVICE, 1'b0, 1'b1, 8'h5A);
    send_fields(MODE_UNUSED, 1'b1, 1'b1, 8'hFF);
    send_fields(MODE_PUT, 1'b1, 1'b1, 8'h00);
    send_fields(MODE_PUT, 1'b0, 1'b0, 8'hFF);
    send_fields(MODE_SERVICE, 1'b1, 1'b1, 8'hFF);
    send_fields(MODE_SERVICE, 1'b1, 1'b0, 8'h00);
    send_fields(MODE_GET, 1'b1, 1'b1, 8'hA5);
    send_fields(MODE_GET, 1'b0, 1'b0, 8'h00);
    send_fields(MODE_GET, 1'b0, 1'b0, 8'h00);
    send_fields(MODE_SERVICE, 1'b0, 1'b1, 8'h00);
    send_fields(MODE_SERVICE, 1'b0, 1'b0, 8'hFF);
    send_fields(MODE_SERVICE, 1'b0, 1'b1, 8'h00);
  endtask

  // fill and drain each ring past full and empty
  task automatic test_ring_sweeps();
    for (int round = 0; round < 12; round++) begin
      calm = (round % 3 == 2);
      for (int k = 0; k < 35; k++) send_op(random_op(op_mix_t'(round % 4)));
    end
    calm = 1'b0;
  endtask

  task automatic test_random_mix();
    for (int k = 0; k < 500; k++) begin
      if (k % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      send_op(random_op(($urandom_range(0, 1) != 0) ? MIX_ANY
                        : op_mix_t'($urandom_range(0, 3))));
    end
    calm = 1'b0;
  endtask

  // long receiver hold-off while items keep coming, then free running
  task automatic test_backpressure();
    hold_req = HOLD_CYCLES;
    calm = 1'b1;
    for (int k = 0; k < 60; k++) send_op(random_op(MIX_ANY));
    calm = 1'b0;
    for (int k = 0; k < 100; k++) send_op(random_op(MIX_ANY));
  endtask

  // result side: ready pattern and comparison
  initial begin
    int unsigned hold_left, stall_left, r;
    uart_res_t   got, want;
    hold_left = 0;
    stall_left = 0;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        n_checked++;
        if (pending_results.size() == 0) begin
          $error("result transfer with no pending expectation: %h", out_tdata);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.tx_send !== want.tx_send) begin
            $error("tx_send exp %0d got %0d", want.tx_send, got.tx_send); errors++;
          end
          if (got.tx_byte !== want.tx_byte) begin
            $error("tx_byte exp %h got %h", want.tx_byte, got.tx_byte); errors++;
          end
          if (got.rx_dropped !== want.rx_dropped) begin
            $error("rx_dropped exp %0d got %0d", want.rx_dropped, got.rx_dropped); errors++;
          end
          if (got.put_count !== want.put_count) begin
            $error("put_count exp %0d got %0d", want.put_count, got.put_count); errors++;
          end
          if (got.tx_kick !== want.tx_kick) begin
            $error("tx_kick exp %0d got %0d", want.tx_kick, got.tx_kick); errors++;
          end
          if (got.read_value !== want.read_value) begin
            $error("read_value exp %h got %h", want.read_value, got.read_value); errors++;
          end
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      r = $urandom_range(0, 99);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && r < 20) begin
        stall_left = (r < 2) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin
    int unsigned idle;
    idle = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
      if (idle >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results pending",
                 idle, pending_results.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_drops = 0;
    n_full_puts = 0;
    n_empty_gets = 0;
    n_tx_sent = 0;
    calm = 1'b0;
    hold_req = 0;
    rx_rd = '0;
    rx_wr = '0;
    tx_rd = '0;
    tx_wr = '0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_cases();
    test_ring_sweeps();
    test_random_mix();
    test_backpressure();
    in_tvalid <= 1'b0;

    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d operations sent, %0d results checked", n_sent, n_checked);
    $display("%0d bytes transmitted, %0d rx drops, %0d puts into full ring, %0d empty gets",
             n_tx_sent, n_drops, n_full_puts, n_empty_gets);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
